// ===== hdl/blob_obstacle_avoid_fsm_core_macros.svh =====
// Assertion macros used by the port checker of the obstacle avoider.
`ifndef BLOB_OBSTACLE_AVOID_FSM_CORE_MACROS_SVH
`define BLOB_OBSTACLE_AVOID_FSM_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define BOA_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error("boa assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define BOA_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error("boa assertion failed");

`endif

// ===== hdl/boa_pkg.sv =====
// Package with widths, codes and reset values of the obstacle avoider.
`default_nettype none

package boa_pkg;

	// field widths
	localparam int X_W       = 9;
	localparam int AREA_W    = 17;
	localparam int TAG_W     = 16;
	localparam int THR_W     = 17;
	localparam int SPEED_W   = 10;
	localparam int RATE_W    = 10;
	localparam int GAIN_W    = 16;
	localparam int TICK_W    = 8;
	localparam int YAW_W     = 11;
	localparam int MODE_W    = 2;
	localparam int ACT_W     = 2;
	localparam int TALLY_W   = 16;
	localparam int ASUM_W    = 32;

	// stream and configuration port widths
	localparam int IN_TDATA_W  = 48;
	localparam int OUT_TDATA_W = 56;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 17;

	// serial multiplier operand widths
	localparam int MUL_A_W = 17;
	localparam int MUL_B_W = 9;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;

	// defaults of the top level parameters
	localparam int CENTRE_COLUMN_DEF = 160;
	localparam int ACC_WIDTH_DEF     = 48;

	// input kind
	localparam logic CMD_BLOB = 1'b0;

	// action codes
	localparam logic [ACT_W-1:0] ACT_NONE = 2'd0;
	localparam logic [ACT_W-1:0] ACT_FWD  = 2'd1;
	localparam logic [ACT_W-1:0] ACT_STOP = 2'd2;
	localparam logic [ACT_W-1:0] ACT_TURN = 2'd3;

	// avoider modes
	localparam logic [MODE_W-1:0] MODE_FWD  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_STOP = 2'd1;
	localparam logic [MODE_W-1:0] MODE_TURN = 2'd2;
	localparam logic [MODE_W-1:0] MODE_COOL = 2'd3;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_AREA_THR   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CRUISE     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_RATE_LIMIT = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_TURN_GAIN  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_STOP_TICKS = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_COOL_TICKS = 3'd5;

	// register reset values
	localparam logic [THR_W-1:0]   AREA_THR_RST   = 17'd13824;
	localparam logic [SPEED_W-1:0] CRUISE_RST     = 10'd256;
	localparam logic [RATE_W-1:0]  RATE_LIMIT_RST = 10'd256;
	localparam logic [GAIN_W-1:0]  TURN_GAIN_RST  = 16'd328;
	localparam logic [TICK_W-1:0]  STOP_TICKS_RST = 8'd8;
	localparam logic [TICK_W-1:0]  COOL_TICKS_RST = 8'd10;

	// exit hysteresis ratio, area below NUM/DEN of threshold
	localparam int HYST_NUM = 49;
	localparam int HYST_DEN = 50;
	localparam int HYST_W   = THR_W + 6;

endpackage

`default_nettype wire

// ===== hdl/boa_mul.sv =====
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
`default_nettype none

module boa_mul import boa_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic [MUL_A_W-1:0] a,
	input  wire logic [MUL_B_W-1:0] b,
	output logic                    done,
	output logic [MUL_P_W-1:0]      prod
);

	localparam int CNT_W = $clog2(MUL_B_W);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MUL_B_W - 1);

	logic               busy_q;
	logic               done_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [MUL_P_W-1:0] a_sh_q;
	logic [MUL_B_W-1:0] b_sh_q;
	logic [MUL_P_W-1:0] acc_q;

	// sequence control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// shift operands and add one partial product per cycle
	always_ff @(posedge clk) begin
		if (start) begin
			a_sh_q <= MUL_P_W'(a);
			b_sh_q <= b;
			acc_q  <= '0;
		end else if (busy_q) begin
			if (b_sh_q[0]) begin
				acc_q <= acc_q + a_sh_q;
			end
			a_sh_q <= {a_sh_q[MUL_P_W-2:0], 1'b0};
			b_sh_q <= {1'b0, b_sh_q[MUL_B_W-1:1]};
		end
	end

	assign done = done_q;
	assign prod = acc_q;

endmodule

`default_nettype wire

// ===== hdl/boa_div.sv =====
// Bit-serial restoring divider, one quotient bit per cycle, low quotient bits kept.
`default_nettype none

module boa_div import boa_pkg::*; #(
	parameter int N_W = ACC_WIDTH_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [N_W-1:0]    dividend,
	input  wire logic [ASUM_W-1:0] divisor,
	output logic                   done,
	output logic [X_W-1:0]         quot
);

	localparam int CNT_W = $clog2(N_W);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(N_W - 1);

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [N_W-1:0]    num_q;
	logic [ASUM_W-1:0] den_q;
	logic [ASUM_W-1:0] rem_q;
	logic [X_W-1:0]    quot_q;
	logic [ASUM_W:0]   rem_sh;
	logic [ASUM_W:0]   rem_sub;
	logic              qbit;

	// shift in the next dividend bit and trial subtract
	always_comb begin
		rem_sh  = {rem_q, num_q[N_W-1]};
		rem_sub = rem_sh - {1'b0, den_q};
		qbit    = !rem_sub[ASUM_W];
	end

	// sequence control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath: remainder, dividend shifter and quotient shifter
	always_ff @(posedge clk) begin
		if (start) begin
			num_q  <= dividend;
			den_q  <= divisor;
			rem_q  <= '0;
			quot_q <= '0;
		end else if (busy_q) begin
			rem_q  <= qbit ? rem_sub[ASUM_W-1:0] : rem_sh[ASUM_W-1:0];
			num_q  <= {num_q[N_W-2:0], 1'b0};
			quot_q <= {quot_q[X_W-2:0], qbit};
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule

`default_nettype wire

// ===== hdl/blob_obstacle_avoid_fsm_core.sv =====
// Blob-driven obstacle avoider: accumulators, serial arithmetic and mode machine.
// Blob report with tag zero: runs through the bit-serial multiplier, then ready again.
// Guided tick: the bit-serial divider (skipped for an empty frame), then the multiplier,
// then the step, which registers the result. Other items are accepted and dropped.
// One item is worked on at a time; a held result stalls only ticks.
// Reset (arst_n low) resets all but datapath and payload registers at once; no clearing pass.
`default_nettype none

module blob_obstacle_avoid_fsm_core import boa_pkg::*; #(
	parameter int CENTRE_COLUMN = CENTRE_COLUMN_DEF,
	parameter int ACC_WIDTH     = ACC_WIDTH_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	// input stream
	input  wire logic                   s_tvalid,
	output logic                        s_tready,
	// tdata: blob_x[8:0], rpt_area[26:9], blob_tag[42:27], guided[43], zero [47:44]
	input  wire logic [IN_TDATA_W-1:0]  s_tdata,
	// tuser: command[0]
	input  wire logic                   s_tuser,
	// result stream
	output logic                        m_tvalid,
	input  wire logic                   m_tready,
	// tdata: action[1:0], speed_out[11:2], yaw_rate_out[22:12], mode_now[24:23],
	//        blobs_seen[40:25], centre_x[49:41], zero [55:50]
	output logic [OUT_TDATA_W-1:0]      m_tdata,
	// configuration writes
	input  wire logic                   cfg_valid,
	output logic                        cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

	localparam logic [X_W-1:0] CENTRE = X_W'(CENTRE_COLUMN);

	// sequencer states
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_BMUL = 3'd1;
	localparam logic [2:0] ST_DIV  = 3'd2;
	localparam logic [2:0] ST_TGO  = 3'd3;
	localparam logic [2:0] ST_TMUL = 3'd4;
	localparam logic [2:0] ST_STEP = 3'd5;

	logic [2:0] state_q;

	// configuration registers
	logic [THR_W-1:0]   area_thr_q;
	logic [SPEED_W-1:0] cruise_q;
	logic [RATE_W-1:0]  rate_limit_q;
	logic [GAIN_W-1:0]  turn_gain_q;
	logic [TICK_W-1:0]  stop_ticks_q;
	logic [TICK_W-1:0]  cool_ticks_q;

	// avoider state
	logic [ACC_WIDTH-1:0] wsum_q;
	logic [ASUM_W-1:0]    area_sum_q;
	logic [TALLY_W-1:0]   tally_q;
	logic [X_W-1:0]       mean_x_q;
	logic [ASUM_W-1:0]    strength_q;
	logic [MODE_W-1:0]    mode_q;
	logic [TICK_W-1:0]    timer_q;
	logic                 turn_left_q;
	logic [RATE_W-1:0]    turn_rate_q;
	logic [AREA_W-1:0]    rpt_area_q;

	// output register
	logic                   m_tvalid_q;
	logic [OUT_TDATA_W-1:0] m_tdata_q;

	// input fields
	logic               in_cmd;
	logic [X_W-1:0]     in_x;
	logic [AREA_W:0]    in_area_raw;
	logic [TAG_W-1:0]   in_tag;
	logic               in_guided;
	logic [AREA_W-1:0]  in_area;
	logic               in_acc;

	// arithmetic units
	logic               mul_start;
	logic [MUL_A_W-1:0] mul_a;
	logic [MUL_B_W-1:0] mul_b;
	logic               mul_done;
	logic [MUL_P_W-1:0] mul_p;
	logic               div_start;
	logic               div_done;
	logic [X_W-1:0]     div_q;

	// accumulation and step logic
	logic [ACC_WIDTH:0]   wsum_ext;
	logic [ASUM_W:0]      asum_ext;
	logic [X_W-1:0]       mag;
	logic                 off_pos;
	logic [AREA_W-1:0]    rate_raw;
	logic [RATE_W-1:0]    rate_pick;
	logic                 hyst_exit;
	logic                 timer_exp;
	logic [TICK_W-1:0]    timer_dec;
	logic                 step_fire;
	logic [ACT_W-1:0]     act_nxt;
	logic [SPEED_W-1:0]   speed_nxt;
	logic [YAW_W-1:0]     yaw_nxt;
	logic [MODE_W-1:0]    mode_nxt;
	logic [TICK_W-1:0]    timer_nxt;
	logic                 turn_left_nxt;
	logic [RATE_W-1:0]    turn_rate_nxt;
	logic                 strength_clr;

	// unpack the input transaction
	always_comb begin
		in_cmd      = s_tuser;
		in_x        = s_tdata[8:0];
		in_area_raw = s_tdata[26:9];
		in_tag      = s_tdata[42:27];
		in_guided   = s_tdata[43];
		in_area     = in_area_raw[AREA_W] ? '0 : in_area_raw[AREA_W-1:0];
	end

	assign s_tready  = (state_q == ST_IDLE);
	assign in_acc    = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;

	// start strobes and operand select for the shared multiplier and the divider
	always_comb begin
		mul_start = 1'b0;
		div_start = 1'b0;
		if (in_acc && in_cmd == CMD_BLOB && in_tag == '0) begin
			mul_start = 1'b1;
		end
		if (in_acc && in_cmd != CMD_BLOB && in_guided && area_sum_q != '0) begin
			div_start = 1'b1;
		end
		if (state_q == ST_TGO) begin
			mul_start = 1'b1;
		end
		if (state_q == ST_IDLE) begin
			mul_a = in_area;
			mul_b = in_x;
		end else begin
			mul_a = MUL_A_W'(turn_gain_q);
			mul_b = mag;
		end
	end

	boa_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.prod   (mul_p)
	);

	boa_div #(
		.N_W (ACC_WIDTH)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (wsum_q),
		.divisor  (area_sum_q),
		.done     (div_done),
		.quot     (div_q)
	);

	// saturating sums of a blob report
	always_comb begin
		wsum_ext = {1'b0, wsum_q} + (ACC_WIDTH + 1)'(mul_p);
		asum_ext = {1'b0, area_sum_q} + (ASUM_W + 1)'(rpt_area_q);
	end

	// offset of the mean column, turn rate and exit hysteresis
	always_comb begin
		off_pos   = (mean_x_q > CENTRE);
		mag       = (mean_x_q >= CENTRE) ? (mean_x_q - CENTRE) : (CENTRE - mean_x_q);
		rate_raw  = mul_p[AREA_W+7:8];
		rate_pick = (rate_raw < AREA_W'(rate_limit_q)) ? rate_raw[RATE_W-1:0] : rate_limit_q;
		hyst_exit = (strength_q[ASUM_W-1:THR_W] == '0) &&
			(HYST_W'(strength_q[THR_W-1:0]) * HYST_W'(HYST_DEN) <
			 HYST_W'(area_thr_q) * HYST_W'(HYST_NUM));
		timer_exp = (timer_q <= TICK_W'(1));
		timer_dec = timer_exp ? '0 : (timer_q - 1'b1);
	end

	// one step of the avoider machine
	always_comb begin
		act_nxt       = ACT_NONE;
		speed_nxt     = '0;
		yaw_nxt       = '0;
		mode_nxt      = mode_q;
		timer_nxt     = timer_q;
		turn_left_nxt = turn_left_q;
		turn_rate_nxt = turn_rate_q;
		strength_clr  = 1'b0;
		case (mode_q)
			MODE_FWD: begin
				if (strength_q > ASUM_W'(area_thr_q)) begin
					timer_nxt = stop_ticks_q;
					mode_nxt  = MODE_STOP;
				end else begin
					act_nxt   = ACT_FWD;
					speed_nxt = cruise_q;
				end
			end
			MODE_STOP: begin
				act_nxt   = ACT_STOP;
				timer_nxt = timer_dec;
				if (timer_exp) begin
					turn_left_nxt = !off_pos;
					turn_rate_nxt = rate_pick;
					mode_nxt      = MODE_TURN;
				end
			end
			MODE_TURN: begin
				act_nxt = ACT_TURN;
				yaw_nxt = turn_left_q ? (YAW_W'(0) - YAW_W'(turn_rate_q)) : YAW_W'(turn_rate_q);
				if (hyst_exit) begin
					timer_nxt    = cool_ticks_q;
					mode_nxt     = MODE_COOL;
					strength_clr = 1'b1;
				end
			end
			default: begin
				act_nxt   = ACT_FWD;
				speed_nxt = cruise_q;
				timer_nxt = timer_dec;
				if (timer_exp) begin
					mode_nxt = MODE_FWD;
				end
			end
		endcase
	end

	assign step_fire = (state_q == ST_STEP) && (!m_tvalid_q || m_tready);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (mul_start) begin
						state_q <= ST_BMUL;
					end else if (div_start) begin
						state_q <= ST_DIV;
					end else if (in_acc && in_cmd != CMD_BLOB && in_guided) begin
						state_q <= ST_TGO;
					end
				end
				ST_BMUL: begin
					if (mul_done) begin
						state_q <= ST_IDLE;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_TGO;
					end
				end
				ST_TGO: begin
					state_q <= ST_TMUL;
				end
				ST_TMUL: begin
					if (mul_done) begin
						state_q <= ST_STEP;
					end
				end
				ST_STEP: begin
					if (step_fire) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			area_thr_q   <= AREA_THR_RST;
			cruise_q     <= CRUISE_RST;
			rate_limit_q <= RATE_LIMIT_RST;
			turn_gain_q  <= TURN_GAIN_RST;
			stop_ticks_q <= STOP_TICKS_RST;
			cool_ticks_q <= COOL_TICKS_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_AREA_THR:   area_thr_q   <= cfg_data[THR_W-1:0];
				CFG_CRUISE:     cruise_q     <= cfg_data[SPEED_W-1:0];
				CFG_RATE_LIMIT: rate_limit_q <= cfg_data[RATE_W-1:0];
				CFG_TURN_GAIN:  turn_gain_q  <= cfg_data[GAIN_W-1:0];
				CFG_STOP_TICKS: stop_ticks_q <= cfg_data[TICK_W-1:0];
				CFG_COOL_TICKS: cool_ticks_q <= cfg_data[TICK_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// hold the area of an accepted tag-zero report, zero if out of range
	always_ff @(posedge clk) begin
		if (mul_start && state_q == ST_IDLE) begin
			rpt_area_q <= in_area;
		end
	end

	// accumulators, frame latch and avoider state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wsum_q      <= '0;
			area_sum_q  <= '0;
			tally_q     <= '0;
			mean_x_q    <= CENTRE;
			strength_q  <= '0;
			mode_q      <= MODE_FWD;
			timer_q     <= '0;
			turn_left_q <= 1'b0;
			turn_rate_q <= RATE_LIMIT_RST;
		end else begin
			if (state_q == ST_BMUL && mul_done) begin
				wsum_q     <= wsum_ext[ACC_WIDTH] ? '1 : wsum_ext[ACC_WIDTH-1:0];
				area_sum_q <= asum_ext[ASUM_W] ? '1 : asum_ext[ASUM_W-1:0];
				if (tally_q != '1) begin
					tally_q <= tally_q + 1'b1;
				end
			end
			if (in_acc && in_cmd != CMD_BLOB && in_guided && area_sum_q == '0) begin
				strength_q <= '0;
			end
			if (state_q == ST_DIV && div_done) begin
				mean_x_q   <= div_q;
				strength_q <= area_sum_q;
			end
			if (step_fire) begin
				wsum_q      <= '0;
				area_sum_q  <= '0;
				tally_q     <= '0;
				mode_q      <= mode_nxt;
				timer_q     <= timer_nxt;
				turn_left_q <= turn_left_nxt;
				turn_rate_q <= turn_rate_nxt;
				if (strength_clr) begin
					strength_q <= '0;
				end
			end
		end
	end

	// result handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (step_fire) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (step_fire) begin
			m_tdata_q <= {6'b0, mean_x_q, tally_q, mode_nxt, yaw_nxt, speed_nxt, act_nxt};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

`default_nettype wire

// ===== hdl/boa_chk.sv =====
// Port checker of the obstacle avoider and its bind to the top level.
`default_nettype none

`include "blob_obstacle_avoid_fsm_core_macros.svh"

module boa_chk import boa_pkg::*; (
	input wire logic                   clk,
	input wire logic                   arst_n,
	input wire logic                   m_tvalid,
	input wire logic                   m_tready,
	input wire logic [OUT_TDATA_W-1:0] m_tdata
);

	logic [ACT_W-1:0]   act;
	logic [SPEED_W-1:0] speed;
	logic [YAW_W-1:0]   yaw;
	logic [MODE_W-1:0]  mode;

	// split the result transaction
	assign act   = m_tdata[1:0];
	assign speed = m_tdata[11:2];
	assign yaw   = m_tdata[22:12];
	assign mode  = m_tdata[24:23];

	// a stalled result holds
	`BOA_ASSERT_NXT(a_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

	// speed only while flying forward
	`BOA_ASSERT_IMP(a_speed, clk, arst_n, m_tvalid && act != ACT_FWD, speed == '0)

	// yaw rate only while turning
	`BOA_ASSERT_IMP(a_yaw, clk, arst_n, m_tvalid && act != ACT_TURN, yaw == '0)

	// an obstacle just found always leaves the machine stopped
	`BOA_ASSERT_IMP(a_none_stop, clk, arst_n, m_tvalid && act == ACT_NONE, mode == MODE_STOP)

	// a turn step ends turning or in cooldown
	`BOA_ASSERT_IMP(a_turn_mode, clk, arst_n, m_tvalid && act == ACT_TURN,
		mode == MODE_TURN || mode == MODE_COOL)

endmodule

bind blob_obstacle_avoid_fsm_core boa_chk u_boa_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

`default_nettype wire
